// File: rtl/copy_pattern_iteration_detector_unit_assert.svh
`ifndef COPY_PATTERN_ITERATION_DETECTOR_UNIT_ASSERT_SVH
`define COPY_PATTERN_ITERATION_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CPID_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cpid assertion failed");

// Next-cycle implication.
`define CPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cpid assertion failed");

`endif

// File: rtl/cpid_pkg.sv
package cpid_pkg;

	localparam int MAX_SIZES_DEF = 64;
	localparam int SIZE_BITS_DEF = 48;
	localparam int ITER_BITS     = 32;

	typedef enum logic [1:0] {
		REQ_COPY  = 2'd0,
		REQ_SYNC  = 2'd1,
		REQ_OTHER = 2'd2
	} req_t;

	// front to back: classified item waiting in the queue
	typedef struct packed {
		logic valid;
		req_t kind;
	} item_ctl_t;

	// back to result queue: fixed-width result fields
	typedef struct packed {
		logic                 new_iter;
		logic [ITER_BITS-1:0] iter_cnt;
		logic                 locked;
		logic                 ovf;
	} status_t;

	function automatic req_t classify(input logic [1:0] code);
		req_t k;
		if (code == REQ_COPY) begin
			k = REQ_COPY;
		end else if (code == REQ_SYNC) begin
			k = REQ_SYNC;
		end else begin
			k = REQ_OTHER;
		end
		return k;
	endfunction

endpackage

// File: rtl/copy_pattern_iteration_detector_unit.sv
// A result reaches the result ports by way of the front queue, then the match
// engine writes it into the result queue once that queue is not full.
// Throughput: one item per cycle unless res_full; the match engine does one
// table read and one compare per item, the next table entry fetched ahead.
// Reset: arst_n clears the queues, learned length, lock, match and iteration
// state, overflow and training_enable; size table contents stay undefined.
module copy_pattern_iteration_detector_unit #(
	parameter int MAX_SIZES = cpid_pkg::MAX_SIZES_DEF,
	parameter int SIZE_BITS = cpid_pkg::SIZE_BITS_DEF,
	parameter int LEN_W     = $clog2(MAX_SIZES + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic                           cfg_wr_data,
	input  logic                           push,
	output logic                           full,
	input  logic [1:0]                     req_type,
	input  logic [SIZE_BITS-1:0]           transfer_bytes,
	output logic                           empty,
	input  logic                           pop,
	output logic                           new_iteration,
	output logic [cpid_pkg::ITER_BITS-1:0] iteration_count,
	output logic                           pattern_locked,
	output logic [LEN_W-1:0]               pattern_length,
	output logic                           pattern_overflow
);

	localparam int RW = $bits(cpid_pkg::status_t) + LEN_W;

	logic                 train_q;
	cpid_pkg::item_ctl_t  item_ctl;
	logic [SIZE_BITS-1:0] item_bytes;
	logic                 item_pop;
	logic                 res_full;
	logic                 res_push;
	cpid_pkg::status_t    res_status;
	logic [LEN_W-1:0]     res_length;
	logic [RW-1:0]        rq_dout;
	cpid_pkg::status_t    out_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			train_q <= 1'b0;
		end else if (cfg_wr_en) begin
			train_q <= cfg_wr_data;
		end
	end

	cpid_front #(.SIZE_BITS(SIZE_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.req_type      (req_type),
		.transfer_bytes(transfer_bytes),
		.item_ctl      (item_ctl),
		.item_bytes    (item_bytes),
		.item_pop      (item_pop)
	);

	cpid_back #(
		.MAX_SIZES(MAX_SIZES),
		.SIZE_BITS(SIZE_BITS),
		.LEN_W    (LEN_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.train_en  (train_q),
		.item_ctl  (item_ctl),
		.item_bytes(item_bytes),
		.item_pop  (item_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_status(res_status),
		.res_length(res_length)
	);

	cpid_fifo #(.W(RW)) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   ({res_status, res_length}),
		.full  (res_full),
		.pop   (pop),
		.dout  (rq_dout),
		.empty (empty)
	);

	assign out_status       = cpid_pkg::status_t'(rq_dout[RW-1:LEN_W]);
	assign pattern_length   = rq_dout[LEN_W-1:0];
	assign new_iteration    = out_status.new_iter;
	assign iteration_count  = out_status.iter_cnt;
	assign pattern_locked   = out_status.locked;
	assign pattern_overflow = out_status.ovf;

endmodule

// File: rtl/cpid_fifo.sv
module cpid_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign dout    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) wptr_q <= ~wptr_q;
			if (do_pop) rptr_q <= ~rptr_q;
			if (do_push & ~do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop & ~do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= din;
	end

endmodule

// File: rtl/cpid_front.sv
module cpid_front #(
	parameter int SIZE_BITS = cpid_pkg::SIZE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            req_type,
	input  logic [SIZE_BITS-1:0]  transfer_bytes,
	output cpid_pkg::item_ctl_t   item_ctl,
	output logic [SIZE_BITS-1:0]  item_bytes,
	input  logic                  item_pop
);

	localparam int QW = SIZE_BITS + 2;

	logic [QW-1:0]  q_din;
	logic [QW-1:0]  q_dout;
	logic           q_empty;

	// fold the unused code into "other" before queuing
	assign q_din = {cpid_pkg::classify(req_type), transfer_bytes};

	cpid_fifo #(.W(QW)) u_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (q_din),
		.full  (full),
		.pop   (item_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign item_ctl.valid = ~q_empty;
	assign item_ctl.kind  = cpid_pkg::req_t'(q_dout[QW-1 -: 2]);
	assign item_bytes     = q_dout[SIZE_BITS-1:0];

endmodule

// File: rtl/cpid_back.sv
module cpid_back #(
	parameter int MAX_SIZES = cpid_pkg::MAX_SIZES_DEF,
	parameter int SIZE_BITS = cpid_pkg::SIZE_BITS_DEF,
	parameter int LEN_W     = $clog2(MAX_SIZES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 train_en,
	input  cpid_pkg::item_ctl_t  item_ctl,
	input  logic [SIZE_BITS-1:0] item_bytes,
	output logic                 item_pop,
	input  logic                 res_full,
	output logic                 res_push,
	output cpid_pkg::status_t    res_status,
	output logic [LEN_W-1:0]     res_length
);

	localparam int AW = $clog2(MAX_SIZES);
	localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MAX_SIZES);
	localparam logic [LEN_W-1:0] MIN_LOCK = LEN_W'(2);

	logic [SIZE_BITS-1:0] tbl_mem [MAX_SIZES];
	logic [SIZE_BITS-1:0] rdata_q;
	logic [SIZE_BITS-1:0] ent0_q;

	logic [LEN_W-1:0]          cnt_q, cnt_d;
	logic                      locked_q, locked_d;
	logic                      mvalid_q, mvalid_d;
	logic [AW-1:0]             pos_q, pos_d;
	logic                      prev_valid_q;
	cpid_pkg::req_t            prev_q;
	logic [cpid_pkg::ITER_BITS-1:0] iter_q, iter_d;
	logic                      ovf_q, ovf_d;

	logic                 fire;
	logic                 is_copy;
	logic                 hit;
	logic                 wr_en;
	logic [AW-1:0]        rd_addr;
	logic [LEN_W-1:0]     next_idx;
	logic [SIZE_BITS-1:0] cmp_data;
	logic                 prev_chain;

	assign fire     = item_ctl.valid & ~res_full;
	assign item_pop = fire;
	assign res_push = fire;
	assign is_copy  = (item_ctl.kind == cpid_pkg::REQ_COPY);

	assign prev_chain = prev_valid_q &
		((prev_q == cpid_pkg::REQ_COPY) || (prev_q == cpid_pkg::REQ_SYNC));
	assign next_idx   = mvalid_q ? (LEN_W'(pos_q) + LEN_W'(1)) : '0;
	// rdata_q holds the entry after pos_q; entry zero is kept aside
	assign cmp_data   = mvalid_q ? rdata_q : ent0_q;

	always_comb begin
		cnt_d    = cnt_q;
		locked_d = locked_q;
		mvalid_d = mvalid_q;
		pos_d    = pos_q;
		iter_d   = iter_q;
		ovf_d    = ovf_q;
		hit      = 1'b0;
		wr_en    = 1'b0;
		if (fire && train_en) begin
			if (is_copy) begin
				if (!locked_q) begin
					if (cnt_q < MAX_CNT) begin
						wr_en = 1'b1;
						cnt_d = cnt_q + LEN_W'(1);
					end else begin
						ovf_d = 1'b1;
					end
				end else if (mvalid_q && !prev_chain) begin
					mvalid_d = 1'b0;
				end else if (next_idx < cnt_q && cmp_data == item_bytes) begin
					if (next_idx + LEN_W'(1) == cnt_q) begin
						mvalid_d = 1'b0;
						iter_d   = iter_q + 1'b1;
						hit      = 1'b1;
					end else begin
						mvalid_d = 1'b1;
						pos_d    = next_idx[AW-1:0];
					end
				end else begin
					mvalid_d = 1'b0;
				end
			end else if (!locked_q) begin
				if (prev_valid_q && prev_q == cpid_pkg::REQ_COPY &&
						item_ctl.kind == cpid_pkg::REQ_SYNC) begin
					// run goes on
				end else if (cnt_q >= MIN_LOCK) begin
					locked_d = 1'b1;
				end else begin
					cnt_d = '0;
				end
			end
		end
	end

	// fetch the entry after the new match position for the next item
	assign rd_addr = pos_d + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			locked_q     <= 1'b0;
			mvalid_q     <= 1'b0;
			pos_q        <= '0;
			prev_valid_q <= 1'b0;
			prev_q       <= cpid_pkg::REQ_COPY;
			iter_q       <= '0;
			ovf_q        <= 1'b0;
		end else begin
			cnt_q    <= cnt_d;
			locked_q <= locked_d;
			mvalid_q <= mvalid_d;
			pos_q    <= pos_d;
			iter_q   <= iter_d;
			ovf_q    <= ovf_d;
			if (fire) begin
				prev_valid_q <= 1'b1;
				prev_q       <= item_ctl.kind;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) tbl_mem[cnt_q[AW-1:0]] <= item_bytes;
		if (wr_en && cnt_q == '0) ent0_q <= item_bytes;
		rdata_q <= tbl_mem[rd_addr];
	end

	assign res_status.new_iter = hit;
	assign res_status.iter_cnt = iter_d;
	assign res_status.locked   = locked_d;
	assign res_status.ovf      = ovf_d;
	assign res_length          = cnt_d;

endmodule

// File: rtl/cpid_checker.sv
`include "copy_pattern_iteration_detector_unit_assert.svh"

module cpid_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           empty,
	input logic                           pop,
	input logic                           new_iteration,
	input logic [cpid_pkg::ITER_BITS-1:0] iteration_count,
	input logic                           pattern_locked,
	input logic                           pattern_overflow
);

	logic                           xfer;
	logic                           seen_q;
	logic                           locked_seen_q;
	logic                           ovf_seen_q;
	logic [cpid_pkg::ITER_BITS-1:0] last_cnt_q;

	assign xfer = pop & ~empty;

	// remember what earlier result transfers showed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q        <= 1'b0;
			locked_seen_q <= 1'b0;
			ovf_seen_q    <= 1'b0;
			last_cnt_q    <= '0;
		end else if (xfer) begin
			seen_q        <= 1'b1;
			locked_seen_q <= locked_seen_q | pattern_locked;
			ovf_seen_q    <= ovf_seen_q | pattern_overflow;
			last_cnt_q    <= iteration_count;
		end
	end

	`CPID_ASSERT_IMPL(a_lock_sticky, clk, arst_n, xfer && locked_seen_q, pattern_locked)
	`CPID_ASSERT_IMPL(a_ovf_sticky, clk, arst_n, xfer && ovf_seen_q, pattern_overflow)
	`CPID_ASSERT_IMPL(a_iter_step, clk, arst_n, xfer && seen_q, iteration_count == (last_cnt_q + {{(cpid_pkg::ITER_BITS-1){1'b0}}, new_iteration}))
	`CPID_ASSERT_IMPL(a_iter_locked, clk, arst_n, !empty && new_iteration, pattern_locked)

endmodule

bind copy_pattern_iteration_detector_unit cpid_checker u_cpid_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.new_iteration   (new_iteration),
	.iteration_count (iteration_count),
	.pattern_locked  (pattern_locked),
	.pattern_overflow(pattern_overflow)
);

// File: verif/tb_copy_pattern_iteration_detector_unit.sv
module tb_copy_pattern_iteration_detector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cpid_pkg::*;

	localparam int SIZE_W = SIZE_BITS_DEF;
	localparam int TABLE_DEPTH = MAX_SIZES_DEF;
	localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [1:0] REQ_CODE_RESERVED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		bit                 new_iter;
		bit [ITER_BITS-1:0] iter_cnt;
		bit                 locked;
		bit [LEN_W-1:0]     length;
		bit                 ovf;
	} detector_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic                  cfg_wr_data = 1'b0;
	logic                  push = 1'b0;
	logic                  pop = 1'b0;
	logic [1:0]            req_type = 2'd0;
	logic [SIZE_W-1:0]     transfer_bytes = '0;
	logic                  full;
	logic                  empty;
	logic                  new_iteration;
	logic [ITER_BITS-1:0]  iteration_count;
	logic                  pattern_locked;
	logic [LEN_W-1:0]      pattern_length;
	logic                  pattern_overflow;

	// predictor state
	bit [SIZE_W-1:0]    learned_sizes [TABLE_DEPTH];
	int unsigned        learned_count = 0;
	bit                 pat_locked = 0;
	bit                 matching = 0;
	int unsigned        match_idx = 0;
	bit                 have_prev = 0;
	req_t               prev_kind = REQ_COPY;
	bit [ITER_BITS-1:0] iter_total = '0;
	bit                 ovf_seen = 0;
	bit                 train_on = 0;

	detector_status_t   expected_status_q [$];
	bit [SIZE_W-1:0]    size_pool [8];
	int                 send_idle_pct = 0;
	int                 pop_stall_pct = 0;
	int                 errors = 0;
	int                 requests_sent = 0;
	int                 iterations_seen = 0;
	int                 results_checked = 0;
	int                 cycle_count = 0;

	copy_pattern_iteration_detector_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.push             (push),
		.full             (full),
		.req_type         (req_type),
		.transfer_bytes   (transfer_bytes),
		.empty            (empty),
		.pop              (pop),
		.new_iteration    (new_iteration),
		.iteration_count  (iteration_count),
		.pattern_locked   (pattern_locked),
		.pattern_length   (pattern_length),
		.pattern_overflow (pattern_overflow)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still pending", $time, expected_status_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [SIZE_W-1:0] random_bytes();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[SIZE_W-1:0];
	endfunction

	// Advance the predictor by one request and return the status it produces.
	function automatic detector_status_t predict_status(logic [1:0] code,
			logic [SIZE_W-1:0] bytes);
		req_t             kind;
		bit               hit;
		int unsigned      nxt;
		detector_status_t s;
		if (code == REQ_COPY) begin
			kind = REQ_COPY;
		end else if (code == REQ_SYNC) begin
			kind = REQ_SYNC;
		end else begin
			kind = REQ_OTHER;
		end
		hit = 0;
		if (kind == REQ_COPY && train_on) begin
			if (!pat_locked) begin
				if (learned_count < TABLE_DEPTH) begin
					learned_sizes[learned_count] = bytes;
					learned_count++;
				end else begin
					ovf_seen = 1;
				end
			end else if (matching &&
					!(have_prev && (prev_kind == REQ_COPY || prev_kind == REQ_SYNC))) begin
				// interrupted: drop the match without comparing this copy
				matching = 0;
			end else begin
				nxt = matching ? match_idx + 1 : 0;
				if (nxt < learned_count && learned_sizes[nxt] == bytes) begin
					if (nxt + 1 == learned_count) begin
						matching = 0;
						iter_total++;
						hit = 1;
					end else begin
						matching = 1;
						match_idx = nxt;
					end
				end else begin
					matching = 0;
				end
			end
		end
		if (kind != REQ_COPY && !pat_locked && train_on) begin
			if (!(have_prev && prev_kind == REQ_COPY && kind == REQ_SYNC)) begin
				if (learned_count >= 2) begin
					pat_locked = 1;
				end else begin
					learned_count = 0;
				end
			end
		end
		prev_kind = kind;
		have_prev = 1;
		s.new_iter = hit;
		s.iter_cnt = iter_total;
		s.locked = pat_locked;
		s.length = learned_count[LEN_W-1:0];
		s.ovf = ovf_seen;
		return s;
	endfunction

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_results
		detector_status_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_status_q.size() == 0) begin
					errors++;
					$display("%0t: result transfer with nothing pending", $time);
				end else begin
					want = expected_status_q.pop_front();
					check_field("new_iteration", want.new_iter, new_iteration);
					check_field("iteration_count", want.iter_cnt, iteration_count);
					check_field("pattern_locked", want.locked, pattern_locked);
					check_field("pattern_length", want.length, pattern_length);
					check_field("pattern_overflow", want.ovf, pattern_overflow);
					results_checked++;
					if (want.new_iter) begin
						iterations_seen++;
					end
				end
			end
			pop <= ($urandom_range(0, 99) >= pop_stall_pct);
		end
	end

	task automatic push_request(logic [1:0] code, logic [SIZE_W-1:0] bytes);
		detector_status_t st;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		req_type <= code;
		transfer_bytes <= bytes;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		st = predict_status(code, bytes);
		expected_status_q.insert(expected_status_q.size(), st);
		requests_sent++;
	endtask

	// Hold the input side until every pending result has been transferred.
	task automatic wait_results_done();
		push <= 1'b0;
		while (expected_status_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (3) @(posedge clk);
	endtask

	task automatic write_training(bit value);
		wait_results_done();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		train_on = value;
	endtask

	function automatic logic [1:0] random_break_code();
		return ($urandom_range(0, 1) != 0) ? REQ_CODE_RESERVED : REQ_OTHER;
	endfunction

	task automatic drive_random_requests(int count);
		for (int i = 0; i < count; i++) begin
			push_request(2'($urandom_range(0, 3)), random_bytes());
		end
	endtask

	// Single-copy runs, each closed by a break, so the table never locks.
	task automatic drive_short_runs(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					push_request(REQ_COPY, random_bytes());
					push_request(random_break_code(), random_bytes());
				end
				2: begin
					push_request(REQ_SYNC, random_bytes());
				end
				default: begin
					push_request(random_break_code(), random_bytes());
				end
			endcase
		end
	endtask

	// Replay the learned sequence with syncs in between and rare faults.
	task automatic drive_match_stream(int count);
		int          r;
		int unsigned nxt;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 999);
			nxt = matching ? match_idx + 1 : 0;
			if (r < 2) begin
				push_request(REQ_COPY, random_bytes());
			end else if (r < 4) begin
				push_request(random_break_code(), random_bytes());
			end else if (r < 5) begin
				push_request(REQ_COPY, size_pool[$urandom_range(0, 7)]);
			end else if (r < 6) begin
				push_request(REQ_SYNC, random_bytes());
			end else if (have_prev && prev_kind == REQ_COPY && $urandom_range(0, 99) < 25) begin
				push_request(REQ_SYNC, random_bytes());
			end else begin
				push_request(REQ_COPY, learned_sizes[nxt]);
			end
		end
	endtask

	task automatic test_training_disabled();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		push_request(REQ_COPY, '1);
		push_request(REQ_COPY, '0);
		push_request(REQ_SYNC, '1);
		push_request(REQ_OTHER, '0);
		push_request(REQ_CODE_RESERVED, '1);
		push_request(REQ_COPY, 48'h8000_0000_0001);
	endtask

	task automatic test_short_runs_cleared();
		write_training(1);
		push_request(REQ_COPY, '0);
		push_request(REQ_OTHER, '1);
		push_request(REQ_COPY, '1);
		push_request(REQ_CODE_RESERVED, '0);
		push_request(REQ_SYNC, '0);
		push_request(REQ_COPY, 48'h8000_0000_0000);
		push_request(REQ_SYNC, '1);
		push_request(REQ_CODE_RESERVED, '1);
		push_request(REQ_OTHER, '0);
		push_request(REQ_COPY, 48'h0000_0000_0001);
		push_request(REQ_OTHER, '1);
	endtask

	task automatic test_unlocked_churn();
		send_idle_pct = 71;
		pop_stall_pct = 0;
		drive_short_runs(50);
		write_training(0);
		drive_random_requests(50);
		write_training(1);
		drive_short_runs(50);
	endtask

	task automatic test_learn_with_overflow();
		send_idle_pct = 0;
		pop_stall_pct = 71;
		size_pool[0] = '0;
		size_pool[1] = '1;
		size_pool[2] = 48'h0000_0000_0001;
		size_pool[3] = 48'h8000_0000_0000;
		for (int i = 4; i < 8; i++) begin
			size_pool[i] = random_bytes();
		end
		// fill past capacity so the last sizes are dropped
		for (int i = 0; i < TABLE_DEPTH + 6; i++) begin
			push_request(REQ_COPY, size_pool[$urandom_range(0, 7)]);
			if ($urandom_range(0, 99) < 40) begin
				push_request(REQ_SYNC, random_bytes());
			end
		end
		push_request(REQ_OTHER, random_bytes());
	endtask

	task automatic test_iteration_matching();
		send_idle_pct = 0;
		pop_stall_pct = 0;
		drive_match_stream(400);
		send_idle_pct = 71;
		pop_stall_pct = 0;
		drive_match_stream(150);
		wait_results_done();
		drive_match_stream(150);
		send_idle_pct = 0;
		pop_stall_pct = 71;
		drive_match_stream(300);
	endtask

	task automatic test_training_pause_while_locked();
		send_idle_pct = 28;
		pop_stall_pct = 28;
		drive_match_stream(100);
		write_training(0);
		drive_match_stream(40);
		drive_random_requests(20);
		write_training(1);
		drive_match_stream(200);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_training_disabled();
		test_short_runs_cleared();
		test_unlocked_churn();
		test_learn_with_overflow();
		test_iteration_matching();
		test_training_pause_while_locked();
		wait_results_done();
		repeat (8) @(posedge clk);
		if (expected_status_q.size() != 0) begin
			errors++;
		end
		$display("Sent %0d requests, checked %0d results, saw %0d completed iterations.",
			requests_sent, results_checked, iterations_seen);
		$display("Learned length %0d, locked %0d, overflow %0d, %0d mismatches.",
			learned_count, pat_locked, ovf_seen, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
